@@ src/sorted_priority_list_assert.svh @@
// ----------------------------------------------------------------------------
// sorted_priority_list_assert.svh
// Assertion macros used by the sorted priority list checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_LIST_ASSERT_SVH
`define SORTED_PRIORITY_LIST_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define SPL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted_priority_list assertion failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define SPL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted_priority_list assertion failed");

`endif

@@ src/spl_pkg.sv @@
// ----------------------------------------------------------------------------
// spl_pkg
// Request kinds, result status codes and the decoded operation type.
// ----------------------------------------------------------------------------
package spl_pkg;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_POP    = 2'd2;
  localparam logic [1:0] KIND_REMOVE = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_NOTAG = 2'd3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // place: insert or append; otherwise the request drops an entry.
  // sorted: insert at key position; by_tag: drop the first tag match.
  typedef struct packed {
    logic place;
    logic sorted;
    logic by_tag;
  } op_t;

endpackage

@@ src/spl_front.sv @@
// ----------------------------------------------------------------------------
// spl_front
// Input stage: takes request beats, decodes the kind, hands them to the queue.
// ----------------------------------------------------------------------------
module spl_front #(
  parameter int KEY_BITS = 16,
  parameter int TAG_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_kind,
  input  logic [KEY_BITS-1:0] in_key,
  input  logic [TAG_BITS-1:0] in_tag,
  output logic                q_valid,
  input  logic                q_ready,
  output spl_pkg::op_t        q_op,
  output logic [KEY_BITS-1:0] q_key,
  output logic [TAG_BITS-1:0] q_tag
);

  logic                hold;
  logic                hold_next;
  spl_pkg::op_t        op_dec;
  spl_pkg::op_t        op;
  logic [KEY_BITS-1:0] key;
  logic [TAG_BITS-1:0] tag;

  always_comb begin
    op_dec = '0;
    case (in_kind)
      spl_pkg::KIND_INSERT: begin
        op_dec.place  = 1'b1;
        op_dec.sorted = 1'b1;
      end
      spl_pkg::KIND_APPEND: begin
        op_dec.place = 1'b1;
      end
      spl_pkg::KIND_POP: begin
        op_dec = '0;
      end
      spl_pkg::KIND_REMOVE: begin
        op_dec.by_tag = 1'b1;
      end
      default: begin
        op_dec = '0;
      end
    endcase
  end

  assign in_ready = !hold || q_ready;

  always_comb begin
    hold_next = hold;
    if (in_valid && in_ready) begin
      hold_next = 1'b1;
    end else if (q_ready) begin
      hold_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 1'b0;
    end else begin
      hold <= hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op  <= op_dec;
      key <= in_key;
      tag <= in_tag;
    end
  end

  assign q_valid = hold;
  assign q_op    = op;
  assign q_key   = key;
  assign q_tag   = tag;

endmodule

@@ src/spl_fifo.sv @@
// ----------------------------------------------------------------------------
// spl_fifo
// Short command queue between the input stage and the list engine.
// ----------------------------------------------------------------------------
module spl_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic [W-1:0]                   slots [spl_pkg::QUEUE_DEPTH];
  logic [spl_pkg::QPTR_W-1:0]     wr_ptr;
  logic [spl_pkg::QPTR_W-1:0]     rd_ptr;
  logic [spl_pkg::QCNT_W-1:0]     cnt;
  logic                           push;
  logic                           pop;

  assign in_ready  = cnt != spl_pkg::QCNT_W'(spl_pkg::QUEUE_DEPTH);
  assign out_valid = cnt != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

endmodule

@@ src/spl_list.sv @@
// ----------------------------------------------------------------------------
// spl_list
// List engine: a row of slot cells that compare in the load state and shift in
// the apply state, plus the result register.
// ----------------------------------------------------------------------------
module spl_list #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 16,
  parameter int TAG_BITS = 32,
  parameter int CNT_W    = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  spl_pkg::op_t        cmd_op,
  input  logic [KEY_BITS-1:0] cmd_key,
  input  logic [TAG_BITS-1:0] cmd_tag,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [1:0]          res_status,
  output logic [KEY_BITS-1:0] res_key,
  output logic [TAG_BITS-1:0] res_tag,
  output logic [CNT_W-1:0]    res_count
);

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_APPLY = 1'b1;
  localparam int   LVL      = $clog2(DEPTH);

  logic                state;
  logic [CNT_W-1:0]    occ;
  logic [CNT_W-1:0]    occ_next;
  spl_pkg::op_t        cur_op;
  logic [KEY_BITS-1:0] cur_key;
  logic [TAG_BITS-1:0] cur_tag;
  logic [DEPTH-1:0]    hit;
  logic [DEPTH-1:0]    hit_next;
  logic [DEPTH-1:0]    pfx [LVL+1];
  logic [DEPTH-1:0]    ahead;
  logic [DEPTH-1:0]    first;
  logic [KEY_BITS-1:0] key_q [DEPTH];
  logic [TAG_BITS-1:0] tag_q [DEPTH];
  logic [KEY_BITS-1:0] sel_key;
  logic [TAG_BITS-1:0] sel_tag;
  logic                any_hit;
  logic                full;
  logic                empty;
  logic                do_place;
  logic                do_drop;
  logic                load;
  logic                apply;
  logic [1:0]          status;

  assign full      = occ == CNT_W'(DEPTH);
  assign empty     = occ == '0;
  assign cmd_ready = state == ST_LOAD;
  assign load      = cmd_valid && cmd_ready;
  assign apply     = (state == ST_APPLY) && (!res_valid || res_ready);

  // Compare stage: every cell checks itself against the incoming request.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd_op.place) begin
        hit_next[i] = cmd_op.sorted && (CNT_W'(i) < occ) && (key_q[i] > cmd_key);
      end else if (cmd_op.by_tag) begin
        hit_next[i] = (CNT_W'(i) < occ) && (tag_q[i] == cmd_tag);
      end else begin
        hit_next[i] = (i == 0) && !empty;
      end
    end
  end

  // Parallel prefix OR over the registered hit vector.
  assign pfx[0] = hit;
  for (genvar l = 0; l < LVL; l++) begin : g_lvl
    for (genvar g = 0; g < DEPTH; g++) begin : g_bit
      if (g >= (1 << l)) begin : g_or
        assign pfx[l+1][g] = pfx[l][g] | pfx[l][g - (1 << l)];
      end else begin : g_pass
        assign pfx[l+1][g] = pfx[l][g];
      end
    end
  end

  assign ahead[0] = 1'b0;
  for (genvar g = 1; g < DEPTH; g++) begin : g_ahead
    assign ahead[g] = pfx[LVL][g-1];
  end
  assign first   = hit & ~ahead;
  assign any_hit = pfx[LVL][DEPTH-1];

  always_comb begin
    sel_key = '0;
    sel_tag = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_key = sel_key | (first[i] ? key_q[i] : '0);
      sel_tag = sel_tag | (first[i] ? tag_q[i] : '0);
    end
  end

  assign do_place = cur_op.place && !full;
  assign do_drop  = !cur_op.place && any_hit;

  always_comb begin
    if (cur_op.place) begin
      status = full ? spl_pkg::ST_FULL : spl_pkg::ST_DONE;
    end else if (empty) begin
      status = spl_pkg::ST_EMPTY;
    end else if (!any_hit) begin
      status = spl_pkg::ST_NOTAG;
    end else begin
      status = spl_pkg::ST_DONE;
    end
  end

  always_comb begin
    occ_next = occ;
    if (do_place) begin
      occ_next = occ + CNT_W'(1);
    end else if (do_drop) begin
      occ_next = occ - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      occ       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (apply) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (load) begin
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (apply) begin
            state <= ST_LOAD;
            occ   <= occ_next;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_op  <= cmd_op;
      cur_key <= cmd_key;
      cur_tag <= cmd_tag;
      hit     <= hit_next;
    end
    if (apply) begin
      res_status <= status;
      res_key    <= do_drop ? sel_key : '0;
      res_tag    <= do_drop ? sel_tag : '0;
      res_count  <= occ_next;
    end
  end

  // Shift stage: each cell takes data only from its neighbors or the request.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam int PREV = (g > 0) ? g - 1 : 0;
    localparam int NEXT = (g < DEPTH - 1) ? g + 1 : g;

    always_ff @(posedge clk) begin
      if (apply && do_place) begin
        if (ahead[g]) begin
          key_q[g] <= key_q[PREV];
          tag_q[g] <= tag_q[PREV];
        end else if (hit[g] || (!any_hit && (CNT_W'(g) == occ))) begin
          key_q[g] <= cur_key;
          tag_q[g] <= cur_tag;
        end
      end else if (apply && do_drop) begin
        if (ahead[g] || hit[g]) begin
          key_q[g] <= key_q[NEXT];
          tag_q[g] <= tag_q[NEXT];
        end
      end
    end
  end

endmodule

@@ src/sorted_priority_list.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_list
// Bounded key-ordered list with insert, append, pop-front and remove-by-tag.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ channel: s_tuser carries the kind, s_tdata the key
// and tag. Each request gives exactly one result beat on the m_ channel:
// m_tuser carries the status, m_tdata the removed key and tag (zero unless an
// entry left the list) and the entry count after the request.
// An accepted request passes an input register and a two-entry command queue,
// then the list engine handles it in a load state, which compares every slot
// against the request, and an apply state, which shifts the slot row and
// loads the result register; it takes no new request before that is done.
// When m_tready is low the result register holds; the engine finishes the
// compare of the next request and then waits, while the input register and
// queue keep taking up to three more beats before s_tready drops.
// Reset empties the list and clears all valid flags; slot contents are left.
// ----------------------------------------------------------------------------
module sorted_priority_list #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 16,
  parameter int TAG_BITS = 32,
  localparam int CNT_W   = $clog2(DEPTH + 1),
  localparam int SDATA_W = ((KEY_BITS + TAG_BITS + 7) / 8) * 8,
  localparam int MDATA_W = ((KEY_BITS + TAG_BITS + CNT_W + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [SDATA_W-1:0] s_tdata,   // entry_key, entry_tag, zero pad
  input  logic [1:0]         s_tuser,   // kind
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [MDATA_W-1:0] m_tdata,   // out_key, out_tag, entry_count, zero pad
  output logic [1:0]         m_tuser    // status
);

  localparam int CMD_W = $bits(spl_pkg::op_t) + KEY_BITS + TAG_BITS;

  logic                fr_valid;
  logic                fr_ready;
  spl_pkg::op_t        fr_op;
  logic [KEY_BITS-1:0] fr_key;
  logic [TAG_BITS-1:0] fr_tag;
  logic                q_valid;
  logic                q_ready;
  logic [CMD_W-1:0]    q_data;
  spl_pkg::op_t        q_op;
  logic [KEY_BITS-1:0] q_key;
  logic [TAG_BITS-1:0] q_tag;
  logic [KEY_BITS-1:0] res_key;
  logic [TAG_BITS-1:0] res_tag;
  logic [CNT_W-1:0]    res_count;

  spl_front #(
    .KEY_BITS (KEY_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_kind  (s_tuser),
    .in_key   (s_tdata[KEY_BITS-1:0]),
    .in_tag   (s_tdata[KEY_BITS +: TAG_BITS]),
    .q_valid  (fr_valid),
    .q_ready  (fr_ready),
    .q_op     (fr_op),
    .q_key    (fr_key),
    .q_tag    (fr_tag)
  );

  spl_fifo #(
    .W (CMD_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_data   ({fr_op, fr_tag, fr_key}),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  assign q_key = q_data[KEY_BITS-1:0];
  assign q_tag = q_data[KEY_BITS +: TAG_BITS];
  assign q_op  = spl_pkg::op_t'(q_data[CMD_W-1 -: $bits(spl_pkg::op_t)]);

  spl_list #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS),
    .TAG_BITS (TAG_BITS),
    .CNT_W    (CNT_W)
  ) u_list (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (q_valid),
    .cmd_ready  (q_ready),
    .cmd_op     (q_op),
    .cmd_key    (q_key),
    .cmd_tag    (q_tag),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res_status (m_tuser),
    .res_key    (res_key),
    .res_tag    (res_tag),
    .res_count  (res_count)
  );

  assign m_tdata = MDATA_W'({res_count, res_tag, res_key});

endmodule

@@ src/spl_checker.sv @@
// ----------------------------------------------------------------------------
// spl_checker
// Port-level checks on the result channel of the sorted priority list.
// ----------------------------------------------------------------------------
`include "sorted_priority_list_assert.svh"

module spl_checker #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 16,
  parameter int TAG_BITS = 32,
  localparam int CNT_W   = $clog2(DEPTH + 1),
  localparam int MDATA_W = ((KEY_BITS + TAG_BITS + CNT_W + 7) / 8) * 8
) (
  input logic               clk,
  input logic               rst,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [MDATA_W-1:0] m_tdata,
  input logic [1:0]         m_tuser
);

  logic [CNT_W-1:0]    count;
  logic [KEY_BITS-1:0] okey;

  assign count = m_tdata[KEY_BITS + TAG_BITS +: CNT_W];
  assign okey  = m_tdata[KEY_BITS-1:0];

  `SPL_ASSERT_IMP(a_reset_idle, $past(rst), !m_tvalid)
  `SPL_ASSERT_NXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  `SPL_ASSERT_IMP(a_count_range, m_tvalid, count <= CNT_W'(DEPTH))
  `SPL_ASSERT_IMP(a_full_count, m_tvalid && (m_tuser == spl_pkg::ST_FULL), count == CNT_W'(DEPTH) && okey == '0)
  `SPL_ASSERT_IMP(a_empty_count, m_tvalid && (m_tuser == spl_pkg::ST_EMPTY), count == '0 && okey == '0)

endmodule

bind sorted_priority_list spl_checker #(
  .DEPTH    (DEPTH),
  .KEY_BITS (KEY_BITS),
  .TAG_BITS (TAG_BITS)
) u_spl_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

@@ verif/sorted_priority_list_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_list_tb
// Self-checking bench for the sorted priority list. A directed table drives
// the empty, full, no-match, tie and only-entry cases. Random traffic then
// swings the list between empty and full. Every request is applied to a list
// model in the bench; each result beat is checked field by field against the
// table's result or the model's. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module sorted_priority_list_tb;
  import spl_pkg::*;

  localparam int LIST_DEPTH  = 16;
  localparam int SDATA_W     = 48;
  localparam int MDATA_W     = 56;
  localparam int RANDOM_REQS = 1100;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 30;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] key;
    logic [31:0] tag;
    logic [4:0]  count;
  } list_result_t;

  // One request, repeated reps times with key ^ n and tag + n.
  // typed rows carry their result; the others take the model's.
  typedef struct packed {
    logic [1:0]   kind;
    logic [15:0]  key;
    logic [31:0]  tag;
    logic [4:0]   reps;
    logic         typed;
    list_result_t want;
  } req_row_t;

  localparam list_result_t NO_RES = '0;
  localparam int           PLAN_ROWS = 20;

  localparam req_row_t PLAN [PLAN_ROWS] = '{
    '{KIND_POP,    16'h0000, 32'h00000000, 5'd1,  1'b1, '{ST_EMPTY, 16'h0, 32'h0, 5'd0}},
    '{KIND_REMOVE, 16'h0000, 32'h00000000, 5'd1,  1'b1, '{ST_EMPTY, 16'h0, 32'h0, 5'd0}},
    '{KIND_INSERT, 16'hFFFF, 32'hFFFFFFFF, 5'd1,  1'b1, '{ST_DONE,  16'h0, 32'h0, 5'd1}},
    '{KIND_INSERT, 16'h0000, 32'h00000000, 5'd1,  1'b1, '{ST_DONE,  16'h0, 32'h0, 5'd2}},
    // equal keys: second one lands behind the first
    '{KIND_INSERT, 16'h8000, 32'h12345678, 5'd1,  1'b0, NO_RES},
    '{KIND_INSERT, 16'h8000, 32'h9ABCDEF0, 5'd1,  1'b0, NO_RES},
    '{KIND_APPEND, 16'h0001, 32'hA5A5A5A5, 5'd1,  1'b0, NO_RES},
    '{KIND_REMOVE, 16'h0000, 32'hDEADBEEF, 5'd1,  1'b1, '{ST_NOTAG, 16'h0, 32'h0, 5'd5}},
    '{KIND_POP,    16'h0000, 32'h00000000, 5'd1,  1'b0, NO_RES},
    '{KIND_REMOVE, 16'h0000, 32'h9ABCDEF0, 5'd1,  1'b0, NO_RES},
    '{KIND_POP,    16'h0000, 32'h00000000, 5'd2,  1'b0, NO_RES},
    // last entry leaves by tag
    '{KIND_REMOVE, 16'hFFFF, 32'hA5A5A5A5, 5'd1,  1'b0, NO_RES},
    '{KIND_POP,    16'h0000, 32'h00000000, 5'd1,  1'b1, '{ST_EMPTY, 16'h0, 32'h0, 5'd0}},
    '{KIND_INSERT, 16'h5A5A, 32'h00000001, 5'd16, 1'b0, NO_RES},
    '{KIND_INSERT, 16'h1234, 32'h00005678, 5'd1,  1'b1, '{ST_FULL,  16'h0, 32'h0, 5'd16}},
    '{KIND_APPEND, 16'hFFFF, 32'hFFFFFFFF, 5'd1,  1'b1, '{ST_FULL,  16'h0, 32'h0, 5'd16}},
    '{KIND_REMOVE, 16'h0000, 32'h00000008, 5'd1,  1'b0, NO_RES},
    '{KIND_APPEND, 16'hFFFF, 32'h00000000, 5'd1,  1'b0, NO_RES},
    '{KIND_REMOVE, 16'h0000, 32'hFFFFFFFF, 5'd1,  1'b1, '{ST_NOTAG, 16'h0, 32'h0, 5'd16}},
    '{KIND_POP,    16'h0000, 32'h00000000, 5'd2,  1'b0, NO_RES}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [SDATA_W-1:0] s_tdata = '0;   // entry_key, entry_tag
  logic [1:0]         s_tuser = '0;   // kind
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [MDATA_W-1:0] m_tdata;        // out_key, out_tag, entry_count, zero pad
  logic [1:0]         m_tuser;        // status

  // list model
  logic [15:0] held_key [LIST_DEPTH];
  logic [31:0] held_tag [LIST_DEPTH];
  int          held_count = 0;

  list_result_t pending_results [$];
  int           fail_count = 0;
  int           cycle_count = 0;
  bit           steady_send = 1'b0;
  bit           steady_recv = 1'b0;

  sorted_priority_list u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[sorted_priority_list] ERROR");
      $finish;
    end
  end

  // Close the gap left by slot pos.
  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < held_count; i++) begin
      held_key[i] = held_key[i + 1];
      held_tag[i] = held_tag[i + 1];
    end
    held_count--;
  endfunction

  function automatic list_result_t apply_list_op(logic [1:0] kind, logic [15:0] key,
                                                 logic [31:0] tag);
    list_result_t res;
    int           pos;
    res = '0;
    res.status = ST_DONE;
    if (kind == KIND_INSERT || kind == KIND_APPEND) begin
      if (held_count >= LIST_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos = held_count;
        if (kind == KIND_INSERT) begin
          pos = 0;
          while (pos < held_count && held_key[pos] <= key) pos++;
        end
        for (int i = held_count; i > pos; i--) begin
          held_key[i] = held_key[i - 1];
          held_tag[i] = held_tag[i - 1];
        end
        held_key[pos] = key;
        held_tag[pos] = tag;
        held_count++;
      end
    end else if (held_count == 0) begin
      res.status = ST_EMPTY;
    end else if (kind == KIND_POP) begin
      res.key = held_key[0];
      res.tag = held_tag[0];
      drop_entry(0);
    end else begin
      pos = 0;
      while (pos < held_count && held_tag[pos] != tag) pos++;
      if (pos >= held_count) begin
        res.status = ST_NOTAG;
      end else begin
        res.key = held_key[pos];
        res.tag = held_tag[pos];
        drop_entry(pos);
      end
    end
    res.count = 5'(held_count);
    return res;
  endfunction

  task automatic send_req(input logic [1:0] kind, input logic [15:0] key,
                          input logic [31:0] tag, input bit typed,
                          input list_result_t want);
    int           gap;
    list_result_t guess;
    gap = steady_send ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {tag, key};
    do @(posedge clk); while (!s_tready);
    guess = apply_list_op(kind, key, tag);
    pending_results.push_back(typed ? want : guess);
  endtask

  // result side: random stalls, check each beat against the oldest expectation
  initial begin
    int           stall;
    int           beats;
    list_result_t want;
    beats = 0;
    do @(posedge clk); while (rst);
    forever begin
      stall = steady_recv ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      beats++;
      if (beats % 48 == 0) steady_recv = ($urandom_range(0, 3) == 0);
      if (pending_results.size() == 0) begin
        $error("result beat with no request outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tuser != want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser);
          fail_count++;
        end
        if (m_tdata[15:0] != want.key) begin
          $error("out_key: expected %h, got %h", want.key, m_tdata[15:0]);
          fail_count++;
        end
        if (m_tdata[47:16] != want.tag) begin
          $error("out_tag: expected %h, got %h", want.tag, m_tdata[47:16]);
          fail_count++;
        end
        if (m_tdata[52:48] != want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, m_tdata[52:48]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int          tide;
    int          roll;
    bit          place;
    logic [1:0]  kind;
    logic [15:0] key;
    logic [31:0] tag;
    tide = 2;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (PLAN[r]) begin
      for (int n = 0; n < PLAN[r].reps; n++)
        send_req(PLAN[r].kind, PLAN[r].key ^ 16'(n), PLAN[r].tag + 32'(n),
                 PLAN[r].typed, PLAN[r].want);
    end

    for (int i = 0; i < RANDOM_REQS; i++) begin
      // tide: 0 fills the list, 1 drains it, 2 mixes
      if (i % 40 == 0) tide = $urandom_range(0, 2);
      if (i % 64 == 0) steady_send = ($urandom_range(0, 3) == 0);
      // hold off until every result is back
      if (i == RANDOM_REQS / 2) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      roll  = $urandom_range(0, 99);
      place = (tide == 0) ? (roll < 75) : (tide == 1) ? (roll < 25) : (roll < 50);
      if (place)
        kind = ($urandom_range(0, 3) == 0) ? KIND_APPEND : KIND_INSERT;
      else
        kind = ($urandom_range(0, 1) == 0) ? KIND_POP : KIND_REMOVE;
      case ($urandom_range(0, 3))
        0:       key = 16'($urandom_range(0, 3));
        1:       key = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'h0000;
        default: key = 16'($urandom);
      endcase
      if (kind == KIND_REMOVE && held_count > 0 && $urandom_range(0, 3) != 0)
        tag = held_tag[$urandom_range(0, held_count - 1)];
      else if ($urandom_range(0, 2) == 0)
        tag = 32'($urandom_range(0, 7));
      else
        tag = $urandom;
      // occasional noise
      if ($urandom_range(0, 9) == 0) kind = 2'($urandom_range(0, 3));
      send_req(kind, key, tag, 1'b0, NO_RES);
    end
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("[sorted_priority_list] OK");
    end else begin
      $display("[sorted_priority_list] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/spl_pkg.sv
src/spl_front.sv
src/spl_fifo.sv
src/spl_list.sv
src/sorted_priority_list.sv
src/spl_checker.sv
verif/sorted_priority_list_tb.sv
